### hw/rtl/srrw_pkg.sv
// ============================================================================
// srrw_pkg
// Shared sizes, types and codes for the selective repeat receive window.
// ============================================================================
package srrw_pkg;

	// Window geometry.
	localparam int WIN_DEPTH = 4;
	localparam int SEG_BYTES = 8;

	// Fixed field widths.
	localparam int SEQ_W   = 32;
	localparam int DATA_W  = 64;
	localparam int BYTES_W = 4;

	localparam int SLOT_W = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
	localparam int CNT_W  = $clog2(WIN_DEPTH + 1);

	// Result kinds.
	localparam logic KIND_ACK   = 1'b0;
	localparam logic KIND_DELIV = 1'b1;

	typedef struct packed {
		logic [SEQ_W-1:0]   seq;
		logic [DATA_W-1:0]  data;
		logic [BYTES_W-1:0] bytes;
	} slot_entry_t;

	typedef struct packed {
		logic             start;
		logic [SEQ_W-1:0] value;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [SLOT_W-1:0] slot;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_STORE,
		ST_MARK,
		ST_NDIV,
		ST_CHECK,
		ST_ACK,
		ST_RD,
		ST_EMIT
	} st_t;

endpackage

### hw/rtl/srrw_ram.sv
// ============================================================================
// srrw_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module srrw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                                         clk,
	input  logic                                         wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                             wr_data,
	input  logic                                         rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                             rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### hw/rtl/srrw_slot_div.sv
// ============================================================================
// srrw_slot_div
// Registered slot index unit: (value / SEG_BYTES) mod WIN_DEPTH.
// ============================================================================
module srrw_slot_div (
	input  logic             clk,
	input  logic             arst_n,
	input  srrw_pkg::div_req_t req,
	output srrw_pkg::div_rsp_t rsp
);
	import srrw_pkg::*;

	logic              done_q;
	logic [SLOT_W-1:0] slot_q;

	// Segment size and window depth are powers of two, so the index is a
	// plain bit select of the sequence number. The answer is registered and
	// ready in the cycle after the request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= req.start;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			slot_q <= SLOT_W'((req.value / SEQ_W'(SEG_BYTES)) % SEQ_W'(WIN_DEPTH));
		end
	end

	assign rsp.done = done_q;
	assign rsp.slot = slot_q;

endmodule

### hw/rtl/selective_repeat_receive_window.sv
// ============================================================================
// selective_repeat_receive_window
// Receive side of a selective repeat transfer with a buffered slot window.
// ============================================================================
// Each accepted segment transaction produces one acknowledgement followed by
// the in-order deliveries it releases (at most WIN_DEPTH), all carrying the
// done flag as it stands after the segment has been handled; last_of_run
// marks the final result of the segment. Segment data lives in one RAM of
// WIN_DEPTH slots, while per-slot valid and delivered bits, the expected
// sequence number and the final flag are flip-flops. The block handles one
// segment at a time. Its steps are the accepting idle state, the registered
// slot index unit, the slot write and the acknowledgement; for each delivery
// the chain walk marks the slot and then checks the next one, except after
// the last slot of a full window, and the slot data is later read back
// through the single RAM read port and presented. A chain step that crosses
// the wrap of the 32-bit sequence space reruns the slot index unit. A new
// segment is taken only in the idle state, but a finished result may still
// be waiting in the output register at that time.
module selective_repeat_receive_window (
	input  logic                            clk,
	input  logic                            arst_n,
	// Segment channel.
	input  logic                            seg_valid,
	output logic                            seg_stall,
	input  logic [srrw_pkg::SEQ_W-1:0]      seq_no,
	input  logic [srrw_pkg::DATA_W-1:0]     payload,
	input  logic [srrw_pkg::BYTES_W-1:0]    payload_bytes,
	input  logic                            is_last,
	// Result channel.
	output logic                            res_valid,
	input  logic                            res_stall,
	output logic                            kind,
	output logic [srrw_pkg::SEQ_W-1:0]      out_seq_no,
	output logic                            out_is_last,
	output logic [srrw_pkg::DATA_W-1:0]     out_payload,
	output logic [srrw_pkg::BYTES_W-1:0]    out_bytes,
	output logic                            last_of_run,
	output logic                            done_res
);
	import srrw_pkg::*;

	localparam logic [SEQ_W-1:0]   SEG_STEP = SEQ_W'(SEG_BYTES);
	localparam logic [SEQ_W-1:0]   SPAN     = SEQ_W'(WIN_DEPTH * SEG_BYTES);
	localparam logic [BYTES_W-1:0] SEG_MAX  = BYTES_W'(SEG_BYTES);

	st_t state_q, state_n;

	// Segment being handled.
	logic [SEQ_W-1:0]   seq_q;
	logic [DATA_W-1:0]  data_q;
	logic [BYTES_W-1:0] nb_q;
	logic               last_q;
	logic [SLOT_W-1:0]  slot_q;

	// Window state.
	logic [WIN_DEPTH-1:0] valid_q, deliv_q;
	logic [SEQ_W-1:0]     expected_q;
	logic                 final_q;

	// Chain walk and delivery bookkeeping.
	logic [SEQ_W-1:0]  t_q, emit_seq_q;
	logic [SLOT_W-1:0] cur_q, nxt_q, k_q, j_q;
	logic [SLOT_W-1:0] slot_list_q [WIN_DEPTH];
	logic [CNT_W-1:0]  ndel_q;
	logic              done_q;

	// Output register.
	logic               res_valid_q;
	logic               kind_q, is_last_o_q, lor_q, done_o_q;
	logic [SEQ_W-1:0]   seq_o_q;
	logic [DATA_W-1:0]  data_o_q;
	logic [BYTES_W-1:0] bytes_o_q;

	// RAM and slot index unit.
	logic              wr_en, rd_en;
	logic [SLOT_W-1:0] rd_addr;
	slot_entry_t       wr_ent, rd_ent;
	logic [$bits(slot_entry_t)-1:0] rd_raw;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	// Control decodes.
	logic              accept, out_free, in_window, starts_run;
	logic              walk_end, chain_ok, done_now, emit_last;
	logic [SEQ_W-1:0]  t_next;
	logic              t_wraps;
	logic [SLOT_W-1:0] cur_inc;
	logic [BYTES_W-1:0] nb_sat;
	logic [DATA_W-1:0]  data_masked;
	logic               out_load_ack, out_load_deliv;

	assign accept   = seg_valid && !seg_stall;
	assign out_free = !res_valid_q || !res_stall;

	// Saturate the byte count and clear the bytes past it.
	assign nb_sat = (payload_bytes > SEG_MAX) ? SEG_MAX : payload_bytes;
	always_comb begin
		for (int b = 0; b < DATA_W / 8; b++) begin
			data_masked[b*8 +: 8] = (BYTES_W'(b) < nb_sat) ? payload[b*8 +: 8] : 8'h00;
		end
	end

	assign in_window  = (seq_q - expected_q) < SPAN;
	assign starts_run = in_window && (seq_q == expected_q);
	assign {t_wraps, t_next} = {1'b0, t_q} + {1'b0, SEG_STEP};
	assign cur_inc    = (cur_q == SLOT_W'(WIN_DEPTH - 1)) ? '0 : cur_q + 1'b1;
	assign walk_end   = (k_q == SLOT_W'(WIN_DEPTH - 1));
	assign chain_ok   = valid_q[nxt_q] && !deliv_q[nxt_q] && (rd_ent.seq == t_next);
	assign done_now   = final_q && ((valid_q & ~deliv_q) == '0);
	assign emit_last  = ((CNT_W'(j_q) + 1'b1) == ndel_q);

	assign wr_ent.seq   = seq_q;
	assign wr_ent.data  = data_q;
	assign wr_ent.bytes = nb_q;
	assign rd_ent       = slot_entry_t'(rd_raw);

	// Next state and strobes.
	always_comb begin
		state_n        = state_q;
		seg_stall      = 1'b1;
		wr_en          = 1'b0;
		rd_en          = 1'b0;
		rd_addr        = cur_inc;
		div_req.start  = 1'b0;
		div_req.value  = seq_no;
		out_load_ack   = 1'b0;
		out_load_deliv = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				seg_stall     = 1'b0;
				div_req.start = seg_valid;
				if (seg_valid) begin
					state_n = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					state_n = ST_STORE;
				end
			end
			ST_STORE: begin
				wr_en   = in_window;
				state_n = starts_run ? ST_MARK : ST_ACK;
			end
			ST_MARK: begin
				if (walk_end) begin
					state_n = ST_ACK;
				end else if (t_wraps) begin
					div_req.start = 1'b1;
					div_req.value = t_next;
					state_n       = ST_NDIV;
				end else begin
					rd_en   = 1'b1;
					rd_addr = cur_inc;
					state_n = ST_CHECK;
				end
			end
			ST_NDIV: begin
				if (div_rsp.done) begin
					rd_en   = 1'b1;
					rd_addr = div_rsp.slot;
					state_n = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_n = chain_ok ? ST_MARK : ST_ACK;
			end
			ST_ACK: begin
				if (out_free) begin
					out_load_ack = 1'b1;
					state_n      = (ndel_q == '0) ? ST_IDLE : ST_RD;
				end
			end
			ST_RD: begin
				rd_en   = 1'b1;
				rd_addr = slot_list_q[j_q];
				state_n = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					out_load_deliv = 1'b1;
					state_n        = emit_last ? ST_IDLE : ST_RD;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Window control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			deliv_q     <= '0;
			expected_q  <= '0;
			final_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_STORE && in_window) begin
				valid_q[slot_q] <= 1'b1;
				deliv_q[slot_q] <= 1'b0;
				if (last_q) begin
					final_q <= 1'b1;
				end
			end
			if (state_q == ST_MARK) begin
				deliv_q[cur_q] <= 1'b1;
				if (walk_end) begin
					expected_q <= t_next;
				end
			end
			if (state_q == ST_CHECK && !chain_ok) begin
				expected_q <= t_next;
			end
			if (out_load_ack || out_load_deliv) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Payload and bookkeeping registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			seq_q  <= seq_no;
			data_q <= data_masked;
			nb_q   <= nb_sat;
			last_q <= is_last;
		end
		if (state_q == ST_DIV && div_rsp.done) begin
			slot_q <= div_rsp.slot;
		end
		if (state_q == ST_STORE) begin
			t_q    <= seq_q;
			cur_q  <= slot_q;
			k_q    <= '0;
			ndel_q <= '0;
		end
		if (state_q == ST_MARK) begin
			slot_list_q[k_q] <= cur_q;
			ndel_q           <= CNT_W'(k_q) + 1'b1;
			if (!walk_end && !t_wraps) begin
				nxt_q <= cur_inc;
			end
		end
		if (state_q == ST_NDIV && div_rsp.done) begin
			nxt_q <= div_rsp.slot;
		end
		if (state_q == ST_CHECK && chain_ok) begin
			t_q   <= t_next;
			cur_q <= nxt_q;
			k_q   <= k_q + 1'b1;
		end
		if (out_load_ack) begin
			done_q      <= done_now;
			j_q         <= '0;
			emit_seq_q  <= seq_q;
			kind_q      <= KIND_ACK;
			seq_o_q     <= seq_q;
			is_last_o_q <= last_q;
			data_o_q    <= '0;
			bytes_o_q   <= '0;
			lor_q       <= (ndel_q == '0);
			done_o_q    <= done_now;
		end
		if (out_load_deliv) begin
			j_q         <= j_q + 1'b1;
			emit_seq_q  <= emit_seq_q + SEG_STEP;
			kind_q      <= KIND_DELIV;
			seq_o_q     <= emit_seq_q;
			is_last_o_q <= 1'b0;
			data_o_q    <= rd_ent.data;
			bytes_o_q   <= rd_ent.bytes;
			lor_q       <= emit_last;
			done_o_q    <= done_q;
		end
	end

	srrw_ram #(
		.WIDTH($bits(slot_entry_t)),
		.DEPTH(WIN_DEPTH)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (slot_q),
		.wr_data (wr_ent),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_raw)
	);

	srrw_slot_div u_slot_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign res_valid   = res_valid_q;
	assign kind        = kind_q;
	assign out_seq_no  = seq_o_q;
	assign out_is_last = is_last_o_q;
	assign out_payload = data_o_q;
	assign out_bytes   = bytes_o_q;
	assign last_of_run = lor_q;
	assign done_res    = done_o_q;

	// The final flag is sticky once an in-window last segment has been stored.
	a_final_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(final_q))
		else $error("final flag dropped");

	// The expected sequence only moves at the end of a chain walk.
	a_expected_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(expected_q) |-> ($past(state_q) == ST_MARK || $past(state_q) == ST_CHECK))
		else $error("expected sequence changed outside a chain walk");

	// Slot writes and reads never share a cycle.
	a_ram_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("slot RAM read and write in the same cycle");

	// Delivery emission never runs past the number of slots walked.
	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (CNT_W'(j_q) < ndel_q && ndel_q <= CNT_W'(WIN_DEPTH)))
		else $error("delivery index out of range");

endmodule

### bench/selective_repeat_receive_window_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// selective_repeat_receive_window_tb
// Self-checking bench for the selective repeat receive window. A
// predictor keeps its own copy of the slot window and computes the
// acknowledgement and in-order deliveries that each segment transaction must
// produce. A checker compares every accepted result against the oldest
// prediction. Directed cases come first, then random traffic under several
// idle and stall mixes.
// ============================================================================
module selective_repeat_receive_window_tb;
	import srrw_pkg::*;

	localparam int CLK_PERIOD   = 8;
	localparam int RESET_CYCLES = 5;
	localparam int TAIL_CYCLES  = 40;
	localparam int MAX_REPORTS  = 10;
	localparam int RANDOM_ITEMS = 80;

	// Timeout: 340 segments, each with up to five results, each result
	// possibly held by a long stall run, plus sender gaps and the block's own
	// chain walk. 2 ms is several times that worst case.
	localparam longint TIMEOUT_NS = 64'd2_000_000;

	localparam logic [SEQ_W-1:0] SEQ_STEP = SEG_BYTES;
	localparam logic [SEQ_W-1:0] WIN_SPAN = WIN_DEPTH * SEG_BYTES;

	// One result as it leaves the block, in port order.
	typedef struct packed {
		logic               kind;
		logic [SEQ_W-1:0]   seqn;
		logic               is_last;
		logic [DATA_W-1:0]  data;
		logic [BYTES_W-1:0] nbytes;
		logic               run_end;
		logic               done;
	} window_result_t;

	// ------------------------------------------------------------------------
	// Clock, reset and DUT ports. Every input holds a known value from time 0.
	// ------------------------------------------------------------------------
	logic               clk           = 1'b0;
	logic               arst_n        = 1'b0;
	logic               seg_valid     = 1'b0;
	logic               seg_stall;
	logic [SEQ_W-1:0]   seq_no        = '0;
	logic [DATA_W-1:0]  payload       = '0;
	logic [BYTES_W-1:0] payload_bytes = '0;
	logic               is_last       = 1'b0;
	logic               res_valid;
	logic               res_stall     = 1'b0;
	logic               kind;
	logic [SEQ_W-1:0]   out_seq_no;
	logic               out_is_last;
	logic [DATA_W-1:0]  out_payload;
	logic [BYTES_W-1:0] out_bytes;
	logic               last_of_run;
	logic               done_res;

	always #(CLK_PERIOD / 2) clk = ~clk;

	selective_repeat_receive_window dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.seg_valid     (seg_valid),
		.seg_stall     (seg_stall),
		.seq_no        (seq_no),
		.payload       (payload),
		.payload_bytes (payload_bytes),
		.is_last       (is_last),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.kind          (kind),
		.out_seq_no    (out_seq_no),
		.out_is_last   (out_is_last),
		.out_payload   (out_payload),
		.out_bytes     (out_bytes),
		.last_of_run   (last_of_run),
		.done_res      (done_res)
	);

	// ------------------------------------------------------------------------
	// Predictor state: a private copy of the receive window.
	// ------------------------------------------------------------------------
	logic [SEQ_W-1:0]   win_seq   [WIN_DEPTH];
	logic               win_valid [WIN_DEPTH];
	logic               win_taken [WIN_DEPTH];
	logic [DATA_W-1:0]  win_data  [WIN_DEPTH];
	logic [BYTES_W-1:0] win_bytes [WIN_DEPTH];
	logic [SEQ_W-1:0]   next_seq;
	logic               final_flag;

	window_result_t pending_results[$];

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int mismatches    = 0;
	int segments_sent = 0;
	int deliveries    = 0;
	int dropped_segs  = 0;
	int done_results  = 0;

	initial begin
		for (int i = 0; i < WIN_DEPTH; i++) begin
			win_valid[i] = 1'b0;
			win_taken[i] = 1'b0;
		end
		next_seq   = '0;
		final_flag = 1'b0;
	end

	function automatic int unsigned slot_index(input logic [SEQ_W-1:0] s);
		return (s / SEQ_STEP) % WIN_DEPTH;
	endfunction

	// Works out the acknowledgement and every delivery that one accepted
	// segment releases, updates the window copy and queues the results.
	task automatic predict_segment(input logic [SEQ_W-1:0] s, input logic [DATA_W-1:0] d,
			input logic [BYTES_W-1:0] nb_in, input logic lst);
		window_result_t run[$];
		window_result_t r;
		logic [BYTES_W-1:0] nb;
		logic [DATA_W-1:0] kept;
		logic [SEQ_W-1:0] walk;
		logic in_win;
		logic more;
		logic all_done;
		int unsigned cur;
		int unsigned nxt;
		int steps;

		// Counts above the segment size saturate; bytes past the count read
		// back as zero.
		nb = (nb_in > SEG_BYTES) ? BYTES_W'(SEG_BYTES) : nb_in;
		kept = d;
		if (nb < 8)
			kept = d & ((64'd1 << (8 * nb)) - 64'd1);

		r = '{kind: KIND_ACK, seqn: s, is_last: lst, data: '0, nbytes: '0,
			run_end: 1'b0, done: 1'b0};
		run.push_back(r);

		// Distance is taken modulo 2^32, so stale duplicates land far away.
		in_win = ((s - next_seq) < WIN_SPAN);
		if (in_win) begin
			cur = slot_index(s);
			win_seq[cur]   = s;
			win_data[cur]  = kept;
			win_bytes[cur] = nb;
			win_valid[cur] = 1'b1;
			win_taken[cur] = 1'b0;
			if (lst)
				final_flag = 1'b1;
		end else begin
			dropped_segs++;
		end

		if (in_win && s == next_seq) begin
			walk  = s;
			steps = 0;
			more  = 1'b1;
			while (more) begin
				cur = slot_index(walk);
				nxt = slot_index(walk + SEQ_STEP);
				win_taken[cur] = 1'b1;
				r = '{kind: KIND_DELIV, seqn: walk, is_last: 1'b0, data: win_data[cur],
					nbytes: win_bytes[cur], run_end: 1'b0, done: 1'b0};
				run.push_back(r);
				steps++;
				// The chain goes on only into a filled, undelivered slot that holds
				// exactly the following sequence number.
				if (steps >= WIN_DEPTH || !win_valid[nxt] || win_taken[nxt] ||
						win_seq[nxt] != win_seq[cur] + SEQ_STEP)
					more = 1'b0;
				else
					walk = walk + SEQ_STEP;
			end
			next_seq = walk + SEQ_STEP;
		end

		// Slots that were never filled count as delivered.
		all_done = final_flag;
		for (int i = 0; i < WIN_DEPTH; i++)
			if (win_valid[i] && !win_taken[i])
				all_done = 1'b0;

		foreach (run[i]) begin
			run[i].done    = all_done;
			run[i].run_end = (i == run.size() - 1);
			pending_results.push_back(run[i]);
		end
	endtask

	// ------------------------------------------------------------------------
	// Segment driver. Called at a rising edge; returns at the edge where the
	// segment was accepted, with seg_valid still high so that a following
	// segment can go out back to back without a second assignment in the
	// same step.
	// ------------------------------------------------------------------------
	task automatic send_segment(input logic [SEQ_W-1:0] s, input logic [DATA_W-1:0] d,
			input logic [BYTES_W-1:0] nb, input logic lst);
		if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
			seg_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct);
		end
		seg_valid     <= 1'b1;
		seq_no        <= s;
		payload       <= d;
		payload_bytes <= nb;
		is_last       <= lst;
		do
			@(posedge clk);
		while (seg_stall);
		segments_sent++;
		predict_segment(s, d, nb, lst);
	endtask

	// Drops valid right at the accepting edge of the last segment and waits
	// until every predicted result has been taken.
	task automatic drain_results();
		seg_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Result side: random stall and the checker.
	// ------------------------------------------------------------------------
	always @(posedge clk)
		res_stall <= ($urandom_range(0, 99) < stall_pct);

	always @(posedge clk) begin
		window_result_t got;
		window_result_t want;
		if (arst_n && res_valid && !res_stall) begin
			got = '{kind, out_seq_no, out_is_last, out_payload, out_bytes,
				last_of_run, done_res};
			if (got.kind == KIND_DELIV)
				deliveries++;
			if (got.done)
				done_results++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected result kind=%0d seq=%h payload=%h", $time,
						got.kind, got.seqn, got.data);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("%0t: result mismatch", $time);
						$display("  expected kind=%0d seq=%h last=%0d payload=%h bytes=%0d run_end=%0d done=%0d",
							want.kind, want.seqn, want.is_last, want.data, want.nbytes,
							want.run_end, want.done);
						$display("  actual   kind=%0d seq=%h last=%0d payload=%h bytes=%0d run_end=%0d done=%0d",
							got.kind, got.seqn, got.is_last, got.data, got.nbytes,
							got.run_end, got.done);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Directed tests. Each one starts from whatever expected sequence number
	// the previous one left behind.
	// ------------------------------------------------------------------------

	// Plain in-order arrivals with all-ones, all-zero and random data.
	task automatic test_in_order();
		send_segment(next_seq, {DATA_W{1'b1}}, 4'd8, 1'b0);
		send_segment(next_seq, '0, 4'd0, 1'b0);
		send_segment(next_seq, {$urandom, $urandom}, 4'd8, 1'b0);
		drain_results();
	endtask

	// Three segments arrive ahead of the gap; filling the gap then releases a
	// full window of deliveries from one segment.
	task automatic test_full_window_release();
		logic [SEQ_W-1:0] base;
		base = next_seq;
		send_segment(base + 3 * SEQ_STEP, {$urandom, $urandom}, 4'd8, 1'b0);
		send_segment(base + 2 * SEQ_STEP, {$urandom, $urandom}, 4'd5, 1'b0);
		send_segment(base + SEQ_STEP, {$urandom, $urandom}, 4'd8, 1'b0);
		send_segment(base, {$urandom, $urandom}, 4'd8, 1'b0);
		drain_results();
	endtask

	// Segments outside the window are acknowledged only. The last flag on a
	// dropped segment must not arm the done flag.
	task automatic test_out_of_window();
		send_segment(next_seq - SEQ_STEP, {$urandom, $urandom}, 4'd8, 1'b1);
		send_segment(next_seq + WIN_SPAN, {$urandom, $urandom}, 4'd8, 1'b0);
		send_segment({SEQ_W{1'b1}}, {DATA_W{1'b1}}, 4'd15, 1'b1);
		send_segment(32'h8000_0000, '0, 4'd0, 1'b0);
		drain_results();
	endtask

	// Byte counts above the segment size saturate, short counts zero the
	// upper payload bytes.
	task automatic test_byte_counts();
		send_segment(next_seq, {DATA_W{1'b1}}, 4'd15, 1'b0);
		send_segment(next_seq, {DATA_W{1'b1}}, 4'd9, 1'b0);
		send_segment(next_seq, {DATA_W{1'b1}}, 4'd1, 1'b0);
		drain_results();
	endtask

	// Unaligned numbers are stored by integer division. One is overwritten by
	// the aligned segment, the other breaks the chain until it is replaced.
	task automatic test_unaligned();
		logic [SEQ_W-1:0] base;
		base = next_seq;
		send_segment(base + 3, {$urandom, $urandom}, 4'd8, 1'b0);
		send_segment(base + SEQ_STEP + 5, {$urandom, $urandom}, 4'd7, 1'b0);
		send_segment(base, {$urandom, $urandom}, 4'd8, 1'b0);
		send_segment(base + SEQ_STEP, {$urandom, $urandom}, 4'd8, 1'b0);
		drain_results();
	endtask

	// The last segment raises done; the block keeps working afterwards.
	task automatic test_last_and_done();
		send_segment(next_seq, {$urandom, $urandom}, 4'd8, 1'b1);
		send_segment(next_seq, {$urandom, $urandom}, 4'd8, 1'b0);
		drain_results();
	endtask

	// ------------------------------------------------------------------------
	// Random traffic. Most segments come from a sender that stays near the
	// expected number (in order or reordered within the window); the rest are
	// stale duplicates, unaligned numbers, near misses and pure noise.
	// ------------------------------------------------------------------------
	task automatic test_random_traffic(input int idle_pct, input int busy_pct,
			input int count, input bit pause_midway);
		logic [SEQ_W-1:0] s;
		logic [BYTES_W-1:0] nb;
		int pick;
		send_idle_pct = idle_pct;
		stall_pct     = busy_pct;
		for (int n = 0; n < count; n++) begin
			// Hold the sender until the block has handed over everything.
			if (pause_midway && n == count / 2)
				drain_results();
			pick = $urandom_range(0, 99);
			if (pick < 35)
				s = next_seq;
			else if (pick < 70)
				s = next_seq + SEQ_STEP * $urandom_range(1, WIN_DEPTH - 1);
			else if (pick < 80)
				s = next_seq - SEQ_STEP * $urandom_range(1, WIN_DEPTH);
			else if (pick < 88)
				s = next_seq + $urandom_range(0, WIN_DEPTH * SEG_BYTES - 1);
			else if (pick < 94)
				s = next_seq + WIN_SPAN + SEQ_STEP * $urandom_range(0, WIN_DEPTH);
			else
				s = $urandom;
			nb = ($urandom_range(0, 99) < 60) ? 4'd8 : BYTES_W'($urandom_range(0, 15));
			send_segment(s, {$urandom, $urandom}, nb, ($urandom_range(0, 99) < 4));
		end
		drain_results();
		send_idle_pct = 0;
		stall_pct     = 0;
	endtask

	// ------------------------------------------------------------------------
	// Sequence of the run.
	// ------------------------------------------------------------------------
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_in_order();
		test_full_window_release();
		test_out_of_window();
		test_byte_counts();
		test_unaligned();
		test_last_and_done();

		test_random_traffic(0, 0, RANDOM_ITEMS, 1'b0);
		test_random_traffic(52, 0, RANDOM_ITEMS, 1'b1);
		test_random_traffic(0, 52, RANDOM_ITEMS, 1'b0);
		test_random_traffic(10, 10, RANDOM_ITEMS, 1'b0);

		// Give a stray extra result time to show up.
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d segments (%0d outside the window), saw %0d in-order deliveries.",
			segments_sent, dropped_segs, deliveries);
		$display("Results with done set: %0d, mismatches: %0d, predictions left: %0d.",
			done_results, mismatches, pending_results.size());
		if (mismatches == 0 && pending_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#(TIMEOUT_NS);
		$display("Timeout with %0d predictions outstanding.", pending_results.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
